@@ hdl/gql_pkg.sv @@
// gql_pkg: shared types, codes and helpers for the glyph quad layout core.
// Used by gql_vertex_calc and glyph_quad_layout_core; depends on nothing.
package gql_pkg;

	localparam int IN_W  = 80;   // packed input beat width
	localparam int OUT_W = 104;  // packed output beat width

	localparam logic [7:0] CODE_TAB     = 8'd9;
	localparam logic [7:0] CODE_NEWLINE = 8'd10;

	typedef enum logic [2:0] {
		REG_INV_CHAR_SIZE = 3'd0,
		REG_INV_ATLAS_W   = 3'd1,
		REG_INV_ATLAS_H   = 3'd2,
		REG_LINE_HEIGHT   = 3'd3,
		REG_TAB_ADVANCE   = 3'd4
	} cfg_reg_t;

	// Scale factors, all unsigned Q0.16
	typedef struct packed {
		logic [15:0] inv_char;
		logic [15:0] inv_aw;
		logic [15:0] inv_ah;
	} gql_scale_t;

	// Quad corners in whole pixels (screen) and atlas pixels (texture)
	typedef struct packed {
		logic signed [17:0] x0;
		logic signed [17:0] x1;
		logic signed [17:0] y0;
		logic signed [17:0] y1;
		logic [12:0]        u0;
		logic [12:0]        u1;
		logic [12:0]        v0;
		logic [12:0]        v1;
	} gql_pix_t;

	// Scaled quad corners
	typedef struct packed {
		logic signed [15:0] px0;
		logic signed [15:0] px1;
		logic signed [15:0] py0;
		logic signed [15:0] py1;
		logic [15:0]        tu0;
		logic [15:0]        tu1;
		logic [15:0]        tv0;
		logic [15:0]        tv1;
	} gql_quad_t;

	function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
		logic signed [15:0] r;
		if (v > 18'sd32767)
			r = 16'sh7fff;
		else if (v < -18'sd32768)
			r = 16'sh8000;
		else
			r = v[15:0];
		return r;
	endfunction

endpackage

@@ hdl/glyph_quad_layout_core.sv @@
// glyph_quad_layout_core: bitmap-font text layout, one character per input beat.
// Top level; depends on gql_pkg and gql_vertex_calc.
//
// Each input beat carries one character with its atlas metrics. Newline and tab only move
// the pen and give no output; any other code gives four output beats, the corners of the
// glyph quad in the order left-top, right-top, left-bottom, right-bottom, with tlast on
// the fourth. The output register gives one beat per cycle while m_tready is high; newline
// and tab do not wait on it. Three register stages (input, pen and corner coordinates,
// scaled beat register) lie between an input beat and its first output beat. Input beats
// are taken while earlier results still drain. The user must make configuration writes
// only while no character is in flight; the block itself does not enforce it.
module glyph_quad_layout_core #(
	parameter int MAX_CHARS = 256  // vertex index wraps at 4*MAX_CHARS (and at 1024)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// config write port
	input  logic                       cfg_we,
	input  logic [2:0]                 cfg_idx,
	input  logic [15:0]                cfg_data,
	// input stream
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// char_code[7:0], atlas_x[19:8], atlas_y[31:20], glyph_width[39:32],
	// glyph_height[47:40], offset_x[55:48], offset_y[63:56], x_advance[71:64],
	// kern_amount[79:72]
	input  logic [gql_pkg::IN_W-1:0]   s_tdata,
	input  logic                       s_tuser,  // first_of_text[0]
	// output stream
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// pos_x[15:0], pos_y[31:16], tex_u[47:32], tex_v[63:48], vertex_index[73:64],
	// extent_width[88:74], extent_height[103:89]
	output logic [gql_pkg::OUT_W-1:0]  m_tdata,
	output logic                       m_tlast   // last_of_quad
);
	import gql_pkg::*;

	localparam int VTX_WRAP = 4 * MAX_CHARS;

	// configuration
	logic [15:0] inv_char_q, inv_aw_q, inv_ah_q;
	logic [7:0]  line_height_q, tab_adv_q;

	// layout state
	logic signed [15:0] pen_x_q, pen_y_q;
	logic [14:0]        max_r_q, max_b_q;
	logic [9:0]         vcount_q;

	// stage 1: raw beat
	logic              v_s1;
	logic [IN_W-1:0]   item_s1;
	logic              first_s1;

	// stage 2: corner pixels
	logic              v_s2;
	logic              glyph_s2;
	logic              clear_s2;
	gql_pix_t          pix_s2;
	logic [9:0]        vidx_s2;

	// output beat register
	logic              v_q;
	logic [1:0]        corner_q;
	gql_quad_t         quad_q;
	logic [9:0]        vidx_q;
	logic [14:0]       ext_w_q, ext_h_q;

	logic out_free, s2_adv, s2_free, s1_adv, out_load, m_beat;

	assign m_beat   = m_tvalid && m_tready;
	assign out_free = !v_q || (m_tready && corner_q == 2'd3);
	assign s2_adv   = v_s2 && (!glyph_s2 || out_free);
	assign s2_free  = !v_s2 || s2_adv;
	assign s1_adv   = v_s1 && s2_free;
	assign s_tready = !v_s1 || s1_adv;
	assign out_load = s2_adv && glyph_s2;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_char_q    <= 16'd2048;
			inv_aw_q      <= 16'd128;
			inv_ah_q      <= 16'd128;
			line_height_q <= 8'd32;
			tab_adv_q     <= 8'd64;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_INV_CHAR_SIZE: inv_char_q    <= cfg_data;
				REG_INV_ATLAS_W:   inv_aw_q      <= cfg_data;
				REG_INV_ATLAS_H:   inv_ah_q      <= cfg_data;
				REG_LINE_HEIGHT:   line_height_q <= cfg_data[7:0];
				REG_TAB_ADVANCE:   tab_adv_q     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// ---------------- stage 1 ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (s_tready)
			v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1  <= s_tdata;
			first_s1 <= s_tuser;
		end
	end

	// ---------------- pen arithmetic (stage 1 -> 2) ----------------
	logic [7:0]         code;
	logic [11:0]        ax, ay;
	logic [7:0]         gw, gh, adv;
	logic signed [7:0]  ox, oy, kern;
	logic signed [15:0] pen_x_b, pen_y_b;
	logic [9:0]         vc_b;
	logic signed [17:0] x0, y0, px_ext, py_ext, sum_nl, sum_tab, sum_adv;
	logic [10:0]        vc_sum;
	logic [9:0]         vc_next;
	logic signed [15:0] pen_x_n, pen_y_n;
	gql_pix_t           pix_n;

	always_comb begin
		code = item_s1[7:0];
		ax   = item_s1[19:8];
		ay   = item_s1[31:20];
		gw   = item_s1[39:32];
		gh   = item_s1[47:40];
		ox   = item_s1[55:48];
		oy   = item_s1[63:56];
		adv  = item_s1[71:64];
		kern = item_s1[79:72];

		pen_x_b = first_s1 ? 16'sd0 : pen_x_q;
		pen_y_b = first_s1 ? 16'sd0 : pen_y_q;
		vc_b    = first_s1 ? 10'd0 : vcount_q;

		px_ext = {{2{pen_x_b[15]}}, pen_x_b};
		py_ext = {{2{pen_y_b[15]}}, pen_y_b};
		x0     = px_ext + {{10{ox[7]}}, ox};
		y0     = py_ext + {{10{oy[7]}}, oy};

		pix_n.x0 = x0;
		pix_n.x1 = x0 + {10'd0, gw};
		pix_n.y0 = y0;
		pix_n.y1 = y0 + {10'd0, gh};
		pix_n.u0 = {1'b0, ax};
		pix_n.u1 = {1'b0, ax} + {5'd0, gw};
		pix_n.v0 = {1'b0, ay};
		pix_n.v1 = {1'b0, ay} + {5'd0, gh};

		sum_nl  = py_ext + {10'd0, line_height_q};
		sum_tab = px_ext + {10'd0, tab_adv_q};
		sum_adv = px_ext + {10'd0, adv} + {{10{kern[7]}}, kern};

		vc_sum = {1'b0, vc_b} + 11'd4;
		if (int'(vc_sum) >= VTX_WRAP)
			vc_next = 10'd0;
		else
			vc_next = vc_sum[9:0];

		pen_x_n = sat16(sum_adv);
		pen_y_n = pen_y_b;
		if (code == CODE_NEWLINE) begin
			pen_x_n = 16'sd0;
			pen_y_n = sat16(sum_nl);
		end else if (code == CODE_TAB) begin
			pen_x_n = sat16(sum_tab);
		end
	end

	logic is_glyph;
	assign is_glyph = (code != CODE_NEWLINE) && (code != CODE_TAB);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q  <= '0;
			pen_y_q  <= '0;
			vcount_q <= '0;
			v_s2     <= 1'b0;
		end else begin
			if (s2_free)
				v_s2 <= s1_adv;
			if (s1_adv) begin
				pen_x_q  <= pen_x_n;
				pen_y_q  <= pen_y_n;
				vcount_q <= is_glyph ? vc_next : vc_b;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			glyph_s2 <= is_glyph;
			clear_s2 <= first_s1;
			pix_s2   <= pix_n;
			vidx_s2  <= vc_b;
		end
	end

	// ---------------- scaling and extents (stage 2 -> beat register) ----------------
	gql_scale_t scale;
	gql_quad_t  quad_n;
	logic [14:0] mr_b, mb_b, mr_n, mb_n;

	assign scale = '{inv_char: inv_char_q, inv_aw: inv_aw_q, inv_ah: inv_ah_q};

	gql_vertex_calc u_calc (
		.pix   (pix_s2),
		.scale (scale),
		.quad  (quad_n)
	);

	// extents only grow from zero, so a negative far edge never wins
	always_comb begin
		mr_b = clear_s2 ? 15'd0 : max_r_q;
		mb_b = clear_s2 ? 15'd0 : max_b_q;
		mr_n = (glyph_s2 && quad_n.px1 > $signed({1'b0, mr_b})) ? quad_n.px1[14:0] : mr_b;
		mb_n = (glyph_s2 && quad_n.py1 > $signed({1'b0, mb_b})) ? quad_n.py1[14:0] : mb_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_r_q  <= '0;
			max_b_q  <= '0;
			v_q      <= 1'b0;
			corner_q <= '0;
		end else begin
			if (s2_adv) begin
				max_r_q <= mr_n;
				max_b_q <= mb_n;
			end
			if (out_load) begin
				v_q      <= 1'b1;
				corner_q <= 2'd0;
			end else if (m_beat) begin
				corner_q <= corner_q + 2'd1;
				if (corner_q == 2'd3)
					v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			quad_q  <= quad_n;
			vidx_q  <= vidx_s2;
			ext_w_q <= mr_n;
			ext_h_q <= mb_n;
		end
	end

	// ---------------- beat assembly ----------------
	logic [15:0] pos_x, pos_y, tex_u, tex_v;
	logic [9:0]  vertex_index;

	always_comb begin
		pos_x        = corner_q[0] ? quad_q.px1 : quad_q.px0;
		tex_u        = corner_q[0] ? quad_q.tu1 : quad_q.tu0;
		pos_y        = corner_q[1] ? quad_q.py1 : quad_q.py0;
		tex_v        = corner_q[1] ? quad_q.tv1 : quad_q.tv0;
		vertex_index = vidx_q + {8'd0, corner_q};
	end

	assign m_tvalid = v_q;
	assign m_tlast  = (corner_q == 2'd3);
	assign m_tdata  = {ext_h_q, ext_w_q, vertex_index, tex_v, tex_u, pos_y, pos_x};

	// ---------------- assertions ----------------
	a_corner_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(corner_q != 2'd0) |-> v_q)
		else $error("corner count advanced with no quad held");

	a_quad_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(m_beat && m_tlast && !out_load) |=> !m_tvalid)
		else $error("output still valid after last corner without a new quad");

	a_index_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(m_beat && !m_tlast) |=>
			(m_tvalid && m_tdata[73:64] == $past(m_tdata[73:64]) + 10'd1))
		else $error("vertex index did not step by one within a quad");

	a_stall_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && glyph_s2 && v_q && !(m_tready && m_tlast)) |-> !s2_adv)
		else $error("glyph left coordinate stage while beat register busy");

endmodule

@@ hdl/gql_vertex_calc.sv @@
// gql_vertex_calc: scales quad corners to Q7.8 screen and Q0.16 texture coordinates.
// Pure combinational datapath between the coordinate stage and the beat register.
// Depends on gql_pkg.
module gql_vertex_calc (
	input  gql_pkg::gql_pix_t   pix,
	input  gql_pkg::gql_scale_t scale,
	output gql_pkg::gql_quad_t  quad
);
	import gql_pkg::*;

	// pix * inv in Q.16, +0.5 lsb of Q7.8, floor (arith shift), saturate
	function automatic logic signed [15:0] to_q78(input logic signed [17:0] p,
	                                              input logic [15:0] inv);
		logic signed [35:0] prod;
		logic signed [27:0] r;
		logic signed [15:0] res;
		prod = $signed({{18{p[17]}}, p}) * $signed({20'd0, inv});
		prod = prod + 36'sd128;
		r    = prod[35:8];
		if (r > 28'sd32767)
			res = 16'sh7fff;
		else if (r < -28'sd32768)
			res = 16'sh8000;
		else
			res = r[15:0];
		return res;
	endfunction

	function automatic logic [15:0] to_tex(input logic [12:0] p, input logic [15:0] inv);
		logic [28:0] prod;
		prod = {16'd0, p} * {13'd0, inv};
		return (|prod[28:16]) ? 16'hffff : prod[15:0];
	endfunction

	always_comb begin
		quad.px0 = to_q78(pix.x0, scale.inv_char);
		quad.px1 = to_q78(pix.x1, scale.inv_char);
		quad.py0 = to_q78(pix.y0, scale.inv_char);
		quad.py1 = to_q78(pix.y1, scale.inv_char);
		quad.tu0 = to_tex(pix.u0, scale.inv_aw);
		quad.tu1 = to_tex(pix.u1, scale.inv_aw);
		quad.tv0 = to_tex(pix.v0, scale.inv_ah);
		quad.tv1 = to_tex(pix.v1, scale.inv_ah);
	end

endmodule

@@ bench/testbench.sv @@
// testbench: self-checking bench for glyph_quad_layout_core (text layout into glyph quads).
// Needs gql_pkg and the core RTL; predicts every vertex beat and compares it field by field.
module testbench;
	import gql_pkg::*;

	localparam int CHAR_LIMIT  = 256;
	localparam int STALL_LIMIT = 2000;

	typedef struct {
		logic               first;
		logic [7:0]         code;
		logic [11:0]        ax;
		logic [11:0]        ay;
		logic [7:0]         gw;
		logic [7:0]         gh;
		logic signed [7:0]  ox;
		logic signed [7:0]  oy;
		logic [7:0]         adv;
		logic signed [7:0]  kern;
	} glyph_char_t;

	typedef struct {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [15:0]        tex_u;
		logic [15:0]        tex_v;
		logic [9:0]         vidx;
		logic [14:0]        ext_w;
		logic [14:0]        ext_h;
		logic               last;
	} vertex_t;

	typedef enum {GEN_TEXT, GEN_RUN_RIGHT, GEN_RUN_DOWN} text_mix_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [2:0]        cfg_idx = '0;
	logic [15:0]       cfg_data = '0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata = '0;
	logic              s_tuser = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;
	logic              m_tlast;

	// layout state mirrored from the core
	int pen_x, pen_y, ext_right, ext_bottom, vert_count;
	int scale_char = 2048, scale_u = 128, scale_v = 128, line_h = 32, tab_w = 64;

	glyph_char_t char_q[$];
	glyph_char_t char_on_bus;
	vertex_t     corner_q[$];
	vertex_t     beat_want;

	int chars_queued, chars_taken, vertices_seen, mismatch_count;
	int src_gap, sink_gap, hold_left, stall_cycles;
	int gen_glyph_run;
	bit gen_wrap_seen, calm, hold_done;

	glyph_quad_layout_core #(.MAX_CHARS(CHAR_LIMIT)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic longint clamp16(longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	// pixel * Q0.16 reciprocal, rounded half up to Q7.8 (shift floors)
	function automatic longint q78_of(longint pix, longint inv);
		longint q;
		q = (pix * inv + 128) >>> 8;
		return clamp16(q);
	endfunction

	function automatic longint tex_of(longint pix, longint inv);
		longint p;
		p = pix * inv;
		return (p > 65535) ? 65535 : p;
	endfunction

	function automatic void place_char(glyph_char_t c);
		longint xl, xr, yt, yb, ul, ur, vt, vb;
		vertex_t v;
		if (c.first) begin
			pen_x = 0;
			pen_y = 0;
			ext_right = 0;
			ext_bottom = 0;
			vert_count = 0;
		end
		if (c.code == CODE_NEWLINE) begin
			pen_x = 0;
			pen_y = clamp16(pen_y + line_h);
			return;
		end
		if (c.code == CODE_TAB) begin
			pen_x = clamp16(pen_x + tab_w);
			return;
		end
		xl = q78_of(pen_x + int'(c.ox), scale_char);
		xr = q78_of(pen_x + int'(c.ox) + int'(c.gw), scale_char);
		yt = q78_of(pen_y + int'(c.oy), scale_char);
		yb = q78_of(pen_y + int'(c.oy) + int'(c.gh), scale_char);
		ul = tex_of(int'(c.ax), scale_u);
		ur = tex_of(int'(c.ax) + int'(c.gw), scale_u);
		vt = tex_of(int'(c.ay), scale_v);
		vb = tex_of(int'(c.ay) + int'(c.gh), scale_v);
		// extents only grow, so glyphs left of or above the origin leave them alone
		if (xr > ext_right)
			ext_right = xr;
		if (yb > ext_bottom)
			ext_bottom = yb;
		for (int k = 0; k < 4; k++) begin
			v.pos_x = (k & 1) ? xr : xl;
			v.pos_y = (k & 2) ? yb : yt;
			v.tex_u = (k & 1) ? ur : ul;
			v.tex_v = (k & 2) ? vb : vt;
			v.vidx  = vert_count + k;
			v.ext_w = ext_right;
			v.ext_h = ext_bottom;
			v.last  = (k == 3);
			corner_q.push_back(v);
		end
		vert_count += 4;
		if (vert_count >= 4 * CHAR_LIMIT)
			vert_count = 0;
		vert_count &= 'h3ff;
		pen_x = clamp16(pen_x + int'(c.adv) + int'(c.kern));
	endfunction

	function automatic glyph_char_t mk_char(int first, int code, int ax, int ay, int gw,
			int gh, int ox, int oy, int adv, int kern);
		glyph_char_t c;
		c.first = first;
		c.code  = code;
		c.ax    = ax;
		c.ay    = ay;
		c.gw    = gw;
		c.gh    = gh;
		c.ox    = ox;
		c.oy    = oy;
		c.adv   = adv;
		c.kern  = kern;
		return c;
	endfunction

	function automatic glyph_char_t make_char(text_mix_t mix);
		glyph_char_t c;
		int pick;
		// clears stay off until the vertex counter has wrapped once
		c.first = gen_wrap_seen && ($urandom_range(0, 39) == 0);
		c.code  = $urandom_range(0, 255);
		c.ax    = $urandom_range(0, 4095);
		c.ay    = $urandom_range(0, 4095);
		c.gw    = $urandom_range(0, 255);
		c.gh    = $urandom_range(0, 255);
		c.ox    = $urandom_range(0, 255);
		c.oy    = $urandom_range(0, 255);
		c.adv   = $urandom_range(0, 255);
		c.kern  = $urandom_range(0, 255);
		pick    = $urandom_range(0, 99);
		case (mix)
			GEN_TEXT: begin
				if (pick < 6)
					c.code = CODE_NEWLINE;
				else if (pick < 10)
					c.code = CODE_TAB;
				else if (pick < 55) begin
					c.code = $urandom_range(32, 126);
					c.gw   = $urandom_range(0, 40);
					c.gh   = $urandom_range(0, 48);
					c.ox   = $urandom_range(0, 16) - 8;
					c.oy   = $urandom_range(0, 24) - 16;
					c.adv  = $urandom_range(0, 48);
					c.kern = $urandom_range(0, 8) - 4;
				end
			end
			GEN_RUN_RIGHT: begin
				c.first = 1'b0;
				if (pick < 10)
					c.code = CODE_TAB;
				else begin
					c.code = $urandom_range(11, 255);
					c.adv  = $urandom_range(230, 255);
					c.kern = $urandom_range(96, 127);
				end
			end
			GEN_RUN_DOWN: begin
				c.first = 1'b0;
				if (pick < 97)
					c.code = CODE_NEWLINE;
			end
		endcase
		return c;
	endfunction

	task automatic queue_char(glyph_char_t c);
		if (c.first)
			gen_glyph_run = 0;
		if (c.code != CODE_NEWLINE && c.code != CODE_TAB) begin
			gen_glyph_run++;
			if (gen_glyph_run >= CHAR_LIMIT)
				gen_wrap_seen = 1'b1;
		end
		char_q.push_back(c);
		chars_queued++;
	endtask

	task automatic queue_random(text_mix_t mix, int count);
		repeat (count)
			queue_char(make_char(mix));
	endtask

	task automatic write_reg(cfg_reg_t r, int val);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= r;
		cfg_data <= val;
		case (r)
			REG_INV_CHAR_SIZE: scale_char = val & 'hffff;
			REG_INV_ATLAS_W:   scale_u = val & 'hffff;
			REG_INV_ATLAS_H:   scale_v = val & 'hffff;
			REG_LINE_HEIGHT:   line_h = val & 'hff;
			REG_TAB_ADVANCE:   tab_w = val & 'hff;
			default: ;
		endcase
	endtask

	task automatic apply_scales(int inv_char, int inv_w, int inv_h, int lh, int tab);
		write_reg(REG_INV_CHAR_SIZE, inv_char);
		write_reg(REG_INV_ATLAS_W, inv_w);
		write_reg(REG_INV_ATLAS_H, inv_h);
		write_reg(REG_LINE_HEIGHT, lh);
		write_reg(REG_TAB_ADVANCE, tab);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// newline/tab give no beats, so allow the pipeline to empty after the last vertex
	task automatic wait_idle();
		while (chars_taken != chars_queued || corner_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	function automatic void check_field(string name, longint want_v, longint got_v);
		if (want_v != got_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
			mismatch_count++;
		end
	endfunction

	// input side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			src_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				place_char(char_on_bus);
				chars_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (char_q.size() > 0) begin
					char_on_bus = char_q.pop_front();
					s_tdata <= {char_on_bus.kern, char_on_bus.adv, char_on_bus.oy,
						char_on_bus.ox, char_on_bus.gh, char_on_bus.gw, char_on_bus.ay,
						char_on_bus.ax, char_on_bus.code};
					s_tuser  <= char_on_bus.first;
					s_tvalid <= 1'b1;
					if (!calm && $urandom_range(0, 5) == 0)
						src_gap = $urandom_range(1, 3);
				end else
					s_tvalid <= 1'b0;
			end
		end
	end

	// output side: checks each vertex beat and throttles tready
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_gap = 0;
			hold_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				vertices_seen++;
				if (corner_q.size() == 0) begin
					$error("vertex beat with nothing expected: %h", m_tdata);
					mismatch_count++;
				end else begin
					beat_want = corner_q.pop_front();
					check_field("pos_x", beat_want.pos_x, $signed(m_tdata[15:0]));
					check_field("pos_y", beat_want.pos_y, $signed(m_tdata[31:16]));
					check_field("tex_u", beat_want.tex_u, m_tdata[47:32]);
					check_field("tex_v", beat_want.tex_v, m_tdata[63:48]);
					check_field("vertex_index", beat_want.vidx, m_tdata[73:64]);
					check_field("extent_width", beat_want.ext_w, m_tdata[88:74]);
					check_field("extent_height", beat_want.ext_h, m_tdata[103:89]);
					check_field("last_of_quad", beat_want.last, m_tlast);
				end
			end
			// one long back-pressure stretch so the core fills and stalls its input
			if (!hold_done && vertices_seen >= 160) begin
				hold_done = 1'b1;
				hold_left = 90;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				sink_gap = $urandom_range(0, 2);
				m_tready <= 1'b0;
			end else
				m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			stall_cycles <= 0;
		else if (stall_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, reset register values
		queue_char(mk_char(1, 65, 0, 0, 16, 20, 0, 0, 18, 0));
		queue_char(mk_char(0, 0, 4095, 4095, 255, 255, 127, 127, 255, 127));
		queue_char(mk_char(0, 255, 0, 0, 0, 0, -128, -128, 0, -128));
		queue_char(mk_char(0, CODE_NEWLINE, 0, 0, 0, 0, 0, 0, 0, 0));
		queue_char(mk_char(0, CODE_TAB, 0, 0, 0, 0, 0, 0, 0, 0));
		queue_char(mk_char(1, CODE_TAB, 4095, 4095, 255, 255, -1, -1, 255, -1));
		queue_char(mk_char(0, 66, 100, 200, 10, 10, -128, -128, 0, -128));
		queue_char(mk_char(0, 67, 7, 9, 12, 14, -128, 5, 3, 0));
		queue_char(mk_char(1, CODE_NEWLINE, 4095, 4095, 255, 255, 127, 127, 255, 127));
		queue_char(mk_char(0, 11, 1, 1, 1, 1, 1, 1, 1, 1));
		queue_char(mk_char(0, 8, 2048, 1, 128, 1, 1, -1, 128, 1));
		queue_char(mk_char(0, 127, 2048, 2048, 128, 128, 0, -1, 64, -64));
		queue_char(mk_char(0, CODE_TAB, 0, 0, 0, 0, 0, 0, 0, 0));
		queue_char(mk_char(0, CODE_TAB, 0, 0, 0, 0, 0, 0, 0, 0));
		queue_char(mk_char(0, 97, 30, 40, 8, 8, 2, -12, 9, -1));
		queue_char(mk_char(0, CODE_NEWLINE, 0, 0, 0, 0, 0, 0, 0, 0));
		queue_char(mk_char(0, CODE_NEWLINE, 0, 0, 0, 0, 0, 0, 0, 0));
		queue_char(mk_char(0, 128, 4000, 3, 200, 240, -100, 100, 200, 100));
		queue_char(mk_char(0, 32, 0, 0, 0, 0, 0, 0, 8, 0));
		queue_char(mk_char(0, 90, 4095, 0, 0, 255, 0, -128, 255, 127));
		wait_idle();

		// largest scales: drive the pen into saturation, first along x then down
		apply_scales(65535, 65535, 65535, 255, 255);
		queue_random(GEN_RUN_RIGHT, 110);
		queue_random(GEN_RUN_DOWN, 130);
		queue_random(GEN_TEXT, 20);
		wait_idle();

		calm = 1'b1;
		apply_scales(1, 1, 1, 0, 0);
		queue_random(GEN_TEXT, 30);
		wait_idle();
		calm = 1'b0;

		repeat (2) begin
			apply_scales($urandom_range(1, 65535), $urandom_range(1, 4096),
				$urandom_range(1, 65535), $urandom_range(0, 255), $urandom_range(0, 255));
			queue_random(GEN_TEXT, 30);
			wait_idle();
		end

		// closing stretch with no idling; keep going until the vertex count has wrapped
		calm = 1'b1;
		apply_scales($urandom_range(256, 4096), $urandom_range(16, 1024),
			$urandom_range(16, 1024), $urandom_range(0, 255), $urandom_range(0, 255));
		queue_random(GEN_TEXT, 30);
		while (!gen_wrap_seen)
			queue_random(GEN_TEXT, 1);
		wait_idle();

		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/gql_pkg.sv
hdl/gql_vertex_calc.sv
hdl/glyph_quad_layout_core.sv
bench/testbench.sv
